// File: rtl/snq_pkg.sv
// ----------------------------------------------------------------------------
// snq_pkg
// Shared types, constants and helper functions of the scale note quantizer.
// ----------------------------------------------------------------------------
package snq_pkg;

	localparam int NoteW    = 7;
	localparam int NumNotes = 1 << NoteW;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 12;

	localparam logic [NoteW-1:0] DEFAULT_NOTE = 7'd60;
	localparam logic [3:0]       MAX_OCTAVE   = 4'd9;

	localparam logic [3:0]  RST_SCALE_MODE     = 4'd3;
	localparam logic [3:0]  RST_ROOT_PITCH     = 4'd0;
	localparam logic [3:0]  RST_LOWEST_OCTAVE  = 4'd2;
	localparam logic [3:0]  RST_HIGHEST_OCTAVE = 4'd5;
	localparam logic [11:0] RST_CUSTOM_MASK    = 12'd0;

	localparam logic [3:0] SCALE_CUSTOM = 4'd9;

	typedef enum logic [CfgIdxW-1:0] {
		REG_SCALE_MODE     = 3'd0,
		REG_ROOT_PITCH     = 3'd1,
		REG_LOWEST_OCTAVE  = 3'd2,
		REG_HIGHEST_OCTAVE = 3'd3,
		REG_CUSTOM_MASK    = 3'd4
	} cfg_reg_t;

	localparam logic [11:0] SCALE_MASKS [16] = '{
		12'hFFF, 12'h5AD, 12'h9AD, 12'h5AB, 12'h56B, 12'h6AD, 12'h555, 12'hB6D,
		12'h4A9, 12'h000, 12'h5AD, 12'h5AD, 12'h5AD, 12'h5AD, 12'h5AD, 12'h5AD
	};

	typedef struct packed {
		logic [11:0] mask;
		logic [3:0]  root;
		logic [3:0]  lo_p1;
		logic [3:0]  hi_p1;
	} scale_cfg_t;

	function automatic logic [11:0] active_mask(input logic [3:0] mode,
		input logic [11:0] custom);
		logic [11:0] m;
		if (mode == SCALE_CUSTOM) begin
			m = custom;
		end else begin
			m = SCALE_MASKS[mode];
		end
		return m;
	endfunction

	// Quotient by twelve for a 7-bit value, by reciprocal multiplication.
	function automatic logic [3:0] div12(input logic [NoteW-1:0] n);
		logic [12:0] p;
		p = 13'(n) * 13'd43;
		return p[12:9];
	endfunction

endpackage

// File: rtl/snq_scale_map.sv
// ----------------------------------------------------------------------------
// snq_scale_map
// Configuration registers and the registered map of legal notes.
// ----------------------------------------------------------------------------
module snq_scale_map (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [snq_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [snq_pkg::CfgDataW-1:0]  cfg_data,
	output snq_pkg::scale_cfg_t           scale_cfg,
	output logic [snq_pkg::NumNotes-1:0]  legal_q
);

	logic [3:0]  scale_mode_q;
	logic [3:0]  root_pitch_q;
	logic [3:0]  lowest_octave_q;
	logic [3:0]  highest_octave_q;
	logic [11:0] custom_mask_q;
	logic [3:0]  lo_eff;
	logic [3:0]  hi_eff;
	logic [3:0]  lo_p3;
	logic [3:0]  hi_p3;
	logic [snq_pkg::NumNotes-1:0] legal_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_mode_q     <= snq_pkg::RST_SCALE_MODE;
			root_pitch_q     <= snq_pkg::RST_ROOT_PITCH;
			lowest_octave_q  <= snq_pkg::RST_LOWEST_OCTAVE;
			highest_octave_q <= snq_pkg::RST_HIGHEST_OCTAVE;
			custom_mask_q    <= snq_pkg::RST_CUSTOM_MASK;
		end else if (cfg_we) begin
			case (snq_pkg::cfg_reg_t'(cfg_index))
				snq_pkg::REG_SCALE_MODE:     scale_mode_q     <= cfg_data[3:0];
				snq_pkg::REG_ROOT_PITCH:     root_pitch_q     <= cfg_data[3:0];
				snq_pkg::REG_LOWEST_OCTAVE:  lowest_octave_q  <= cfg_data[3:0];
				snq_pkg::REG_HIGHEST_OCTAVE: highest_octave_q <= cfg_data[3:0];
				snq_pkg::REG_CUSTOM_MASK:    custom_mask_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		lo_eff = (lowest_octave_q > snq_pkg::MAX_OCTAVE) ? snq_pkg::MAX_OCTAVE
			: lowest_octave_q;
		hi_eff = (highest_octave_q < lo_eff) ? lo_eff : highest_octave_q;
		if (hi_eff > snq_pkg::MAX_OCTAVE) begin
			hi_eff = snq_pkg::MAX_OCTAVE;
		end
		lo_p3 = lo_eff + 4'd3;
		hi_p3 = hi_eff + 4'd3;
		scale_cfg.mask  = snq_pkg::active_mask(scale_mode_q, custom_mask_q);
		scale_cfg.root  = root_pitch_q;
		scale_cfg.lo_p1 = lo_eff + 4'd1;
		scale_cfg.hi_p1 = hi_eff + 4'd1;
	end

	// Each note splits into octave and semitone above the root; the octave is
	// carried with an offset of two so that notes below the root stay positive.
	for (genvar k = 0; k < snq_pkg::NumNotes; k++) begin : g_note
		localparam int Q = k / 12;
		localparam int R = k % 12;
		logic [5:0] v;
		logic [3:0] semi;
		logic [3:0] oct_p2;
		logic       hit;

		always_comb begin
			v = 6'(R) + 6'd24 - {2'b00, root_pitch_q};
			if (v >= 6'd24) begin
				semi   = 4'(v - 6'd24);
				oct_p2 = 4'(Q + 2);
			end else if (v >= 6'd12) begin
				semi   = 4'(v - 6'd12);
				oct_p2 = 4'(Q + 1);
			end else begin
				semi   = v[3:0];
				oct_p2 = 4'(Q);
			end
			hit = (oct_p2 >= lo_p3) && (oct_p2 <= hi_p3) && scale_cfg.mask[semi];
		end

		assign legal_d[k] = hit;
	end

	always_ff @(posedge clk) begin
		legal_q <= legal_d;
	end

endmodule

// File: rtl/snq_search_pipe.sv
// ----------------------------------------------------------------------------
// snq_search_pipe
// Note register, nearest-neighbor search and result register.
// ----------------------------------------------------------------------------
module snq_search_pipe (
	input  logic                          clk,
	input  logic                          arst_n,
	input  snq_pkg::scale_cfg_t           scale_cfg,
	input  logic [snq_pkg::NumNotes-1:0]  legal_q,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [snq_pkg::NoteW-1:0]     note_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [snq_pkg::NoteW-1:0]     nearest_note,
	output logic                          in_scale,
	output logic                          none_legal
);

	logic                       valid_s1;
	logic [snq_pkg::NoteW-1:0]  note_s1;
	logic                       valid_q;
	logic [snq_pkg::NoteW-1:0]  nearest_q;
	logic                       in_scale_q;
	logic                       none_q;

	logic adv_out;
	logic adv_s1;

	logic                       dn_found;
	logic [snq_pkg::NoteW-1:0]  dn_idx;
	logic                       up_found;
	logic [snq_pkg::NoteW-1:0]  up_idx;
	logic [3:0]                 oct;
	logic [3:0]                 rem;
	logic [5:0]                 pcv;
	logic [3:0]                 pc;
	logic                       in_scale_d;
	logic                       none_d;
	logic [snq_pkg::NoteW-1:0]  dist_dn;
	logic [snq_pkg::NoteW-1:0]  dist_up;
	logic [snq_pkg::NoteW-1:0]  nearest_d;

	assign adv_out  = !valid_q || out_ready;
	assign adv_s1   = !valid_s1 || adv_out;
	assign in_ready = adv_s1;

	always_comb begin
		dn_found = 1'b0;
		dn_idx   = '0;
		up_found = 1'b0;
		up_idx   = '0;
		for (int k = 0; k < snq_pkg::NumNotes; k++) begin
			if (legal_q[k] && (snq_pkg::NoteW'(k) <= note_s1)) begin
				dn_found = 1'b1;
				dn_idx   = snq_pkg::NoteW'(k);
			end
		end
		for (int k = snq_pkg::NumNotes - 1; k >= 0; k--) begin
			if (legal_q[k] && (snq_pkg::NoteW'(k) >= note_s1)) begin
				up_found = 1'b1;
				up_idx   = snq_pkg::NoteW'(k);
			end
		end
	end

	always_comb begin
		oct = snq_pkg::div12(note_s1);
		rem = 4'(note_s1 - 7'(oct) * 7'd12);
		pcv = 6'(rem) + 6'd24 - {2'b00, scale_cfg.root};
		if (pcv >= 6'd24) begin
			pc = 4'(pcv - 6'd24);
		end else if (pcv >= 6'd12) begin
			pc = 4'(pcv - 6'd12);
		end else begin
			pc = pcv[3:0];
		end
		in_scale_d = (oct >= scale_cfg.lo_p1) && (oct <= scale_cfg.hi_p1)
			&& scale_cfg.mask[pc];
	end

	always_comb begin
		none_d  = (legal_q == '0);
		dist_dn = note_s1 - dn_idx;
		dist_up = up_idx - note_s1;
		if (none_d) begin
			nearest_d = snq_pkg::DEFAULT_NOTE;
		end else if (!dn_found) begin
			nearest_d = up_idx;
		end else if (!up_found || (dist_dn <= dist_up)) begin
			nearest_d = dn_idx;
		end else begin
			nearest_d = up_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= in_valid;
			end
			if (adv_out) begin
				valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			note_s1 <= note_in;
		end
		if (adv_out && valid_s1) begin
			nearest_q  <= nearest_d;
			in_scale_q <= in_scale_d;
			none_q     <= none_d;
		end
	end

	assign out_valid    = valid_q;
	assign nearest_note = nearest_q;
	assign in_scale     = in_scale_q;
	assign none_legal   = none_q;

`ifndef SYNTH
	a_none_default: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && none_q |-> (nearest_q == snq_pkg::DEFAULT_NOTE))
		else $error("empty scale must give the default note");

	a_found_when_legal: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !none_d |-> dn_found || up_found)
		else $error("non-empty scale without a neighbor candidate");

	a_down_below: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && dn_found |-> dn_idx <= note_s1)
		else $error("lower candidate lies above the note");

	a_up_above: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && up_found |-> up_idx >= note_s1)
		else $error("upper candidate lies below the note");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(nearest_note))
		else $error("stalled output transaction changed");
`endif

endmodule

// File: rtl/scale_note_quantizer.sv
// ----------------------------------------------------------------------------
// scale_note_quantizer
// Maps a MIDI note to the nearest note of a configured scale.
// ----------------------------------------------------------------------------
// Each input transaction carries one note; each output transaction carries
// the nearest legal note (lower one on a tie), an in-scale flag for the input
// and a flag that the legal note set is empty, in which case the note is 60.
// Both channels use valid/ready. The configuration port writes one register
// per cycle with cfg_we high; the user must write it only while no transaction
// is in flight, and the block itself does not enforce this. The legal note map
// is rebuilt into a register in the cycle after a write. An accepted note sits
// in the input register, and its result is loaded into the output register when
// that register is empty or being read. One transaction is accepted per cycle
// unless both registers are full; the search for the nearest legal notes below
// and above runs between the two registers.
// When the receiver stalls, the result stays in the output register and the
// input register fills behind it; in_ready falls only once both are full.
// Reset clears both registers and loads the default configuration: phrygian
// scale, root C, octaves 2 through 5, empty custom mask.
// ----------------------------------------------------------------------------
module scale_note_quantizer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [snq_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [snq_pkg::CfgDataW-1:0]  cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [snq_pkg::NoteW-1:0]     note_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [snq_pkg::NoteW-1:0]     nearest_note,
	output logic                          in_scale,
	output logic                          none_legal
);

	snq_pkg::scale_cfg_t           scale_cfg;
	logic [snq_pkg::NumNotes-1:0]  legal_q;

	snq_scale_map u_scale_map (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.scale_cfg (scale_cfg),
		.legal_q   (legal_q)
	);

	snq_search_pipe u_search_pipe (
		.clk          (clk),
		.arst_n       (arst_n),
		.scale_cfg    (scale_cfg),
		.legal_q      (legal_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.note_in      (note_in),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.nearest_note (nearest_note),
		.in_scale     (in_scale),
		.none_legal   (none_legal)
	);

endmodule

// File: tb/scale_note_quantizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scale_note_quantizer_tb
// Self-checking testbench for the scale note quantizer.
// ----------------------------------------------------------------------------
// Notes are streamed through the input channel under a series of scale and
// octave settings. Each accepted note is run through a behavioral quantizer
// in the testbench, and every output transaction is compared field by field
// against the oldest prediction. Both channels idle at random, except during
// one long phase that runs at full rate. Settings are changed only while no
// transaction is in flight.
// ----------------------------------------------------------------------------
module scale_note_quantizer_tb;

	localparam int LATENCY        = 1;
	localparam int SETTLE_CYCLES  = 4;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TARGET_NOTES   = 1900;
	localparam int IDLE_PERCENT   = 8;

	localparam logic [3:0] MODE_CHROMATIC  = 4'd0;
	localparam logic [3:0] MODE_WHOLE_TONE = 4'd6;
	localparam logic [3:0] MODE_PENTATONIC = 4'd8;
	localparam logic [3:0] MODE_UNDEFINED  = 4'd13;

	// Interval patterns per scale code; codes above the custom one fall back
	// to natural minor.
	localparam logic [11:0] SCALE_BITS [16] = '{
		12'hFFF, 12'h5AD, 12'h9AD, 12'h5AB, 12'h56B, 12'h6AD, 12'h555, 12'hB6D,
		12'h4A9, 12'h000, 12'h5AD, 12'h5AD, 12'h5AD, 12'h5AD, 12'h5AD, 12'h5AD
	};

	typedef struct {
		logic [snq_pkg::NoteW-1:0] note;
		logic                      in_scale;
		logic                      none_legal;
	} quant_result_t;

	logic                         clk        = 1'b0;
	logic                         arst_n     = 1'b0;
	logic                         cfg_we     = 1'b0;
	snq_pkg::cfg_reg_t            cfg_index  = snq_pkg::REG_SCALE_MODE;
	logic [snq_pkg::CfgDataW-1:0] cfg_data   = '0;
	logic                         in_valid   = 1'b0;
	logic                         in_ready;
	logic [snq_pkg::NoteW-1:0]    note_in    = '0;
	logic                         out_valid;
	logic                         out_ready  = 1'b0;
	logic [snq_pkg::NoteW-1:0]    nearest_note;
	logic                         in_scale;
	logic                         none_legal;

	logic [3:0]  scale_sel  = snq_pkg::RST_SCALE_MODE;
	logic [3:0]  root_sel   = snq_pkg::RST_ROOT_PITCH;
	logic [3:0]  oct_lo_reg = snq_pkg::RST_LOWEST_OCTAVE;
	logic [3:0]  oct_hi_reg = snq_pkg::RST_HIGHEST_OCTAVE;
	logic [11:0] custom_sel = snq_pkg::RST_CUSTOM_MASK;

	logic [snq_pkg::NoteW-1:0] note_queue [$];
	quant_result_t             quantized_q [$];
	int                        err_count    = 0;
	int                        stall_cycles = 0;
	logic                      no_idle      = 1'b0;

	scale_note_quantizer u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.note_in      (note_in),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.nearest_note (nearest_note),
		.in_scale     (in_scale),
		.none_legal   (none_legal)
	);

	always #5 clk = ~clk;

	function automatic quant_result_t quantize_note(input logic [snq_pkg::NoteW-1:0] note);
		quant_result_t res;
		logic [11:0]   pattern;
		logic [127:0]  legal;
		int            lo, hi, o, i, n, gap, best_gap, note_v, oct, pc;
		pattern = (scale_sel == snq_pkg::SCALE_CUSTOM) ? custom_sel : SCALE_BITS[scale_sel];
		lo = (oct_lo_reg > 9) ? 9 : oct_lo_reg;
		hi = (oct_hi_reg < lo) ? lo : oct_hi_reg;
		if (hi > 9) begin
			hi = 9;
		end
		legal = '0;
		for (o = lo; o <= hi; o++) begin
			for (i = 0; i < 12; i++) begin
				n = (o + 1) * 12 + root_sel + i;
				if (pattern[i] && n <= 127) begin
					legal[n] = 1'b1;
				end
			end
		end
		note_v = note;
		res.note = snq_pkg::DEFAULT_NOTE;
		best_gap = 1000;
		for (n = 0; n < 128; n++) begin
			gap = (n > note_v) ? n - note_v : note_v - n;
			if (legal[n] && gap < best_gap) begin
				best_gap = gap;
				res.note = snq_pkg::NoteW'(n);
			end
		end
		oct = note_v / 12;
		pc = (note_v + 24 - root_sel) % 12;
		res.in_scale = (oct >= lo + 1) && (oct <= hi + 1) && pattern[pc];
		res.none_legal = (legal == '0);
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [snq_pkg::NoteW-1:0] got,
		input logic [snq_pkg::NoteW-1:0] want);
		err_count++;
		if (err_count <= 40) begin
			$display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
		end
	endtask

	task automatic queue_note(input logic [snq_pkg::NoteW-1:0] n);
		note_queue.insert(note_queue.size(), n);
	endtask

	// Input driver.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			note_in  <= '0;
		end else if (!in_valid || in_ready) begin
			if (note_queue.size() > 0 &&
				(no_idle || $urandom_range(99) >= IDLE_PERCENT)) begin
				in_valid <= 1'b1;
				note_in  <= note_queue.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
		end
	end

	// Monitor: predicts on input transactions, checks output transactions.
	always @(posedge clk) begin
		quant_result_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				quantized_q.insert(quantized_q.size(), quantize_note(note_in));
			end
			if (out_valid && out_ready) begin
				if (quantized_q.size() == 0) begin
					report_mismatch("unexpected transaction", nearest_note, '0);
				end else begin
					want = quantized_q.pop_front();
					if (nearest_note !== want.note) begin
						report_mismatch("nearest_note", nearest_note, want.note);
					end
					if (in_scale !== want.in_scale) begin
						report_mismatch("in_scale", snq_pkg::NoteW'(in_scale),
							snq_pkg::NoteW'(want.in_scale));
					end
					if (none_legal !== want.none_legal) begin
						report_mismatch("none_legal", snq_pkg::NoteW'(none_legal),
							snq_pkg::NoteW'(want.none_legal));
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				stall_cycles <= 0;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	task automatic drain();
		while (note_queue.size() > 0 || in_valid || quantized_q.size() > 0) begin
			@(negedge clk);
		end
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_reg(input snq_pkg::cfg_reg_t idx, input logic [11:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		case (idx)
			snq_pkg::REG_SCALE_MODE:     scale_sel  = value[3:0];
			snq_pkg::REG_ROOT_PITCH:     root_sel   = value[3:0];
			snq_pkg::REG_LOWEST_OCTAVE:  oct_lo_reg = value[3:0];
			snq_pkg::REG_HIGHEST_OCTAVE: oct_hi_reg = value[3:0];
			snq_pkg::REG_CUSTOM_MASK:    custom_sel = value;
			default: ;
		endcase
	endtask

	task automatic apply_setting(input logic [3:0] mode, input logic [3:0] root,
		input logic [3:0] lo, input logic [3:0] hi, input logic [11:0] mask);
		drain();
		write_reg(snq_pkg::REG_SCALE_MODE, 12'(mode));
		write_reg(snq_pkg::REG_ROOT_PITCH, 12'(root));
		write_reg(snq_pkg::REG_LOWEST_OCTAVE, 12'(lo));
		write_reg(snq_pkg::REG_HIGHEST_OCTAVE, 12'(hi));
		write_reg(snq_pkg::REG_CUSTOM_MASK, mask);
		@(posedge clk);
		cfg_we <= 1'b0;
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic random_setting();
		logic [3:0]  mode, root, lo, hi;
		logic [11:0] mask;
		mode = ($urandom_range(99) < 80) ? 4'($urandom_range(9)) : 4'($urandom_range(15));
		root = ($urandom_range(99) < 85) ? 4'($urandom_range(11)) : 4'($urandom_range(15));
		lo   = ($urandom_range(99) < 85) ? 4'($urandom_range(9)) : 4'($urandom_range(15));
		hi   = ($urandom_range(99) < 85) ? 4'($urandom_range(9)) : 4'($urandom_range(15));
		case ($urandom_range(9))
			0:       mask = 12'h000;
			1:       mask = 12'hFFF;
			default: mask = 12'($urandom_range(4095));
		endcase
		apply_setting(mode, root, lo, hi, mask);
	endtask

	initial begin
		logic [snq_pkg::NoteW-1:0] reset_notes [10] = '{7'd0, 7'd127, 7'd1, 7'd126,
			7'd35, 7'd36, 7'd83, 7'd84, 7'd60, 7'd61};
		int total, count, k, phase;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (reset_notes[j]) begin
			queue_note(reset_notes[j]);
		end

		// Empty custom scale.
		apply_setting(snq_pkg::SCALE_CUSTOM, 4'd0, 4'd0, 4'd9, 12'h000);
		queue_note(7'd0);
		queue_note(7'd127);
		// Lowest octave beyond nine, highest below lowest, root fifteen: empty set.
		apply_setting(MODE_CHROMATIC, 4'd15, 4'd15, 4'd3, 12'h000);
		queue_note(7'd120);
		queue_note(7'd127);
		// Only the top note is legal.
		apply_setting(MODE_WHOLE_TONE, 4'd7, 4'd9, 4'd15, 12'hFFF);
		queue_note(7'd0);
		queue_note(7'd127);
		queue_note(7'd126);
		// Undefined scale code behaves as natural minor.
		apply_setting(MODE_UNDEFINED, 4'd11, 4'd0, 4'd9, 12'hFFF);
		queue_note(7'd22);
		queue_note(7'd23);
		// Root above eleven with a full custom scale.
		apply_setting(snq_pkg::SCALE_CUSTOM, 4'd12, 4'd0, 4'd0, 12'hFFF);
		queue_note(7'd0);
		queue_note(7'd127);
		queue_note(7'd30);
		// Notes below the lowest legal note map up to it.
		apply_setting(MODE_PENTATONIC, 4'd4, 4'd3, 4'd3, 12'h000);
		queue_note(7'd50);
		queue_note(7'd51);

		total = 0;
		phase = 0;
		while (total < TARGET_NOTES) begin
			random_setting();
			no_idle = (phase == 5);
			count = no_idle ? 300 : $urandom_range(20, 120);
			for (k = 0; k < count; k++) begin
				case ($urandom_range(19))
					0:       queue_note(7'd0);
					1:       queue_note(7'd127);
					default: queue_note(7'($urandom_range(127)));
				endcase
			end
			total += count;
			phase++;
			drain();
			no_idle = 1'b0;
		end

		drain();
		if (err_count == 0 && quantized_q.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
